[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the pixel point converter.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RPPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition implies another on the same edge.
`define RPPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  `RPPC_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

[rtl/rppc_pkg.sv]
// Types and constants of the RGB pixel point converter.
// No dependencies; imported by every module of the block.
`default_nettype none
package rppc_pkg;

  typedef enum logic [2:0] {
    MODE_BIN    = 3'd0,
    MODE_GRAY   = 3'd1,
    MODE_ISOL   = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_SEPIA  = 3'd4
  } mode_t;

  localparam logic [1:0] CFG_MODE    = 2'd0;
  localparam logic [1:0] CFG_MAX     = 2'd1;
  localparam logic [1:0] CFG_GRAYMAX = 2'd2;
  localparam logic [1:0] CFG_CHANNEL = 2'd3;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // floor(x / 1000) == (x * REC_M) >> REC_SH for every x below 2^27
  localparam logic [27:0] REC_M  = 28'd137438954;
  localparam int          REC_SH = 37;

  // Restoring divider: 16 quotient bits, two per stage
  localparam int QBITS      = 16;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = QBITS / DIV_STEPS;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_mono;
  } pix_out_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] max_value;
    logic [15:0] gray_max;
    logic [1:0]  channel;
  } cfg_t;

  // State of one pixel once past the front stages
  typedef struct packed {
    pix_in_t          px;
    logic [2:0][15:0] sep;
    logic             bin;
    logic             ovf;
    logic [17:0]      rem;
    logic [15:0]      dlo;
    logic [15:0]      quo;
  } pipe_t;

  // Sepia row dot product in thousandths
  function automatic logic [26:0] sep_dot(input logic [1:0] row, input pix_in_t p);
    logic [26:0] r;
    logic [26:0] g;
    logic [26:0] b;
    r = 27'(p.red);
    g = 27'(p.green);
    b = 27'(p.blue);
    case (row)
      CH_RED:   sep_dot = 27'd393 * r + 27'd769 * g + 27'd189 * b;
      CH_GREEN: sep_dot = 27'd349 * r + 27'd686 * g + 27'd168 * b;
      CH_BLUE:  sep_dot = 27'd272 * r + 27'd534 * g + 27'd131 * b;
      default:  sep_dot = '0;
    endcase
  endfunction

endpackage
`default_nettype wire

[rtl/rppc_front.sv]
// Front three stages: sums, products, sepia scaling and divider setup.
// Depends on rppc_pkg.
`default_nettype none
module rppc_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire rppc_pkg::cfg_t   cfg,
  input  wire logic             in_vld,
  input  wire rppc_pkg::pix_in_t in_pix,
  output logic                  vld_o,
  output rppc_pkg::pipe_t       pipe_o
);
  import rppc_pkg::*;

  localparam logic [15:0] SMASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

  // stage 1
  logic             vld1_r;
  pix_in_t          px1_r, px1_nxt;
  logic [17:0]      sum1_r;
  logic [2:0][26:0] sep1_r;
  // stage 2
  logic             vld2_r;
  pix_in_t          px2_r;
  logic [33:0]      gprod2_r;
  logic [2:0][16:0] sepq2_r, sepq2_nxt;
  logic             bin2_r;
  // stage 3
  logic             vld3_r;
  pipe_t            p3_r, p3_nxt;

  logic [54:0] recp [3];
  logic [17:0] dvsr;
  logic [17:0] hi;

  always_comb begin
    px1_nxt.red   = in_pix.red & SMASK;
    px1_nxt.green = in_pix.green & SMASK;
    px1_nxt.blue  = in_pix.blue & SMASK;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      recp[k]      = 55'(sep1_r[k]) * 55'(REC_M);
      sepq2_nxt[k] = 17'(recp[k] >> REC_SH);
    end
  end

  always_comb begin
    dvsr          = 18'(cfg.max_value) * 18'd3;
    hi            = gprod2_r[33:16];
    p3_nxt.px     = px2_r;
    p3_nxt.bin    = bin2_r;
    for (int k = 0; k < 3; k++) begin
      // clamp to max_value, then mask to the sample width
      if (sepq2_r[k] > 17'(cfg.max_value)) begin
        p3_nxt.sep[k] = cfg.max_value & SMASK;
      end else begin
        p3_nxt.sep[k] = sepq2_r[k][15:0] & SMASK;
      end
    end
    // quotient of 2^16 or more saturates anyway; zero divisor lands here too
    p3_nxt.ovf    = (hi >= dvsr);
    p3_nxt.rem    = hi;
    p3_nxt.dlo    = gprod2_r[15:0];
    p3_nxt.quo    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px1_r    <= px1_nxt;
      sum1_r   <= 18'(px1_nxt.red) + 18'(px1_nxt.green) + 18'(px1_nxt.blue);
      for (int k = 0; k < 3; k++) begin
        sep1_r[k] <= sep_dot(2'(k), px1_nxt);
      end
      px2_r    <= px1_r;
      gprod2_r <= 34'(sum1_r) * 34'(cfg.gray_max);
      sepq2_r  <= sepq2_nxt;
      bin2_r   <= ({1'b0, sum1_r} << 1) > (19'(cfg.max_value) * 19'd3) ? 1'b0 : 1'b1;
      p3_r     <= p3_nxt;
    end
  end

  assign vld_o  = vld3_r;
  assign pipe_o = p3_r;

endmodule
`default_nettype wire

[rtl/rppc_div_stage.sv]
// One stage of the restoring divider for the grayscale level.
// Depends on rppc_pkg.
`default_nettype none
module rppc_div_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic [17:0]     dvsr,
  input  wire logic            vld_i,
  input  wire rppc_pkg::pipe_t pipe_i,
  output logic                 vld_o,
  output rppc_pkg::pipe_t      pipe_o
);
  import rppc_pkg::*;

  logic  vld_r;
  pipe_t p_r, p_nxt;
  logic [18:0] trial;

  always_comb begin
    p_nxt = pipe_i;
    trial = '0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial = {p_nxt.rem, p_nxt.dlo[15]};
      p_nxt.dlo = {p_nxt.dlo[14:0], 1'b0};
      if (trial >= 19'(dvsr)) begin
        p_nxt.rem = 18'(trial - 19'(dvsr));
        p_nxt.quo = {p_nxt.quo[14:0], 1'b1};
      end else begin
        p_nxt.rem = trial[17:0];
        p_nxt.quo = {p_nxt.quo[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r <= p_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign pipe_o = p_r;

endmodule
`default_nettype wire

[rtl/rgb_pixel_point_converter.sv]
// RGB pixel point converter: one RGB pixel in, one converted pixel out.
// Usage:
//   Input channel in_valid/in_stall/in_data carries one pixel per transaction.
//   Output channel out_valid/out_stall/out_data carries one converted pixel.
//   Config port cfg_we/cfg_idx/cfg_wdata writes mode, max_value, gray_max and
//   channel; write only while no pixel is in flight.
// Twelve register stages: three front stages (sums and constant products, gray
// product and sepia scaling, clamp and divider setup), eight divider stages of
// two quotient bits each, and the output register. out_valid rises once an
// accepted pixel has passed through all of them. Throughput is one pixel per
// cycle unless the pipeline holds on out_stall; the 16-bit restoring division
// of the grayscale level is spread over the eight divider stages.
// The whole pipeline advances together; when the output register holds an
// untaken result and out_stall is high, everything holds and in_stall rises.
// Reset (rst_n low, synchronous) clears all valid bits and sets mode to
// binarize, max_value and gray_max to 255 and channel to red.
// Depends on rppc_pkg, rppc_front, rppc_div_stage and assert_macros.svh.
`default_nettype none
module rgb_pixel_point_converter #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rppc_pkg::pix_in_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rppc_pkg::pix_out_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_idx,
  input  wire logic [15:0]        cfg_wdata
);
  import rppc_pkg::*;
  `include "assert_macros.svh"

  cfg_t cfg_r;
  logic adv;
  logic [17:0] dvsr;

  logic  vld_s [DIV_STAGES+1];
  pipe_t pipe_s [DIV_STAGES+1];

  logic     out_valid_r;
  pix_out_t out_data_r, out_nxt;
  pipe_t    fin;
  logic [15:0] gray;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;
  assign dvsr     = 18'(cfg_r.max_value) * 18'd3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= MODE_BIN;
      cfg_r.max_value <= 16'd255;
      cfg_r.gray_max  <= 16'd255;
      cfg_r.channel   <= CH_RED;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MODE:    cfg_r.mode      <= cfg_wdata[2:0];
        CFG_MAX:     cfg_r.max_value <= cfg_wdata;
        CFG_GRAYMAX: cfg_r.gray_max  <= cfg_wdata;
        CFG_CHANNEL: cfg_r.channel   <= cfg_wdata[1:0];
        default:     cfg_r.mode      <= cfg_r.mode;
      endcase
    end
  end

  rppc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .cfg    (cfg_r),
    .in_vld (in_valid && !in_stall),
    .in_pix (in_data),
    .vld_o  (vld_s[0]),
    .pipe_o (pipe_s[0])
  );

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    rppc_div_stage u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .dvsr   (dvsr),
      .vld_i  (vld_s[i]),
      .pipe_i (pipe_s[i]),
      .vld_o  (vld_s[i+1]),
      .pipe_o (pipe_s[i+1])
    );
  end

  assign fin  = pipe_s[DIV_STAGES];
  assign gray = (fin.ovf || (fin.quo > cfg_r.gray_max)) ? cfg_r.gray_max : fin.quo;

  always_comb begin
    out_nxt = '0;
    case (cfg_r.mode)
      MODE_BIN:  out_nxt.out_mono = {15'd0, fin.bin};
      MODE_GRAY: out_nxt.out_mono = gray;
      MODE_ISOL: begin
        out_nxt.out_red   = (cfg_r.channel == CH_RED)   ? fin.px.red   : 16'd0;
        out_nxt.out_green = (cfg_r.channel == CH_GREEN) ? fin.px.green : 16'd0;
        out_nxt.out_blue  = (cfg_r.channel == CH_BLUE)  ? fin.px.blue  : 16'd0;
      end
      MODE_REMOVE: begin
        out_nxt.out_red   = (cfg_r.channel == CH_RED)   ? 16'd0 : fin.px.red;
        out_nxt.out_green = (cfg_r.channel == CH_GREEN) ? 16'd0 : fin.px.green;
        out_nxt.out_blue  = (cfg_r.channel == CH_BLUE)  ? 16'd0 : fin.px.blue;
      end
      MODE_SEPIA: begin
        out_nxt.out_red   = fin.sep[0];
        out_nxt.out_green = fin.sep[1];
        out_nxt.out_blue  = fin.sep[2];
      end
      default: out_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_s[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RPPC_ASSERT_IMPL(a_backpressure, clk, rst_n, out_valid_r && out_stall, in_stall, "stall not passed back")
  `RPPC_ASSERT_IMPL(a_gray_sat, clk, rst_n, out_valid_r && cfg_r.mode == MODE_GRAY && $stable(cfg_r), out_data_r.out_mono <= cfg_r.gray_max, "gray level above gray_max")
  `RPPC_ASSERT_IMPL(a_bin_mono, clk, rst_n, out_valid_r && cfg_r.mode == MODE_BIN && $stable(cfg_r), out_data_r.out_mono <= 16'd1 && out_data_r.out_red == 16'd0, "binarize result malformed")

endmodule
`default_nettype wire
